// ----- src/pic_pkg.sv -----
// ----------------------------------------------------------------------------
// pic_pkg: shared types, command constants and helpers
// Beat formats, action codes, command byte flags and the priority search.
// ----------------------------------------------------------------------------
package pic_pkg;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_RAISE = 2'd2,
        ACT_ACK   = 2'd3
    } action_t;

    // Initialization word sequence positions
    localparam logic [2:0] STEP_ICW1 = 3'd1;
    localparam logic [2:0] STEP_ICW2 = 3'd2;
    localparam logic [2:0] STEP_ICW3 = 3'd3;
    localparam logic [2:0] STEP_ICW4 = 3'd4;
    localparam logic [2:0] STEP_DONE = 3'd5;

    // Command byte decode
    localparam logic [7:0] ICW1_FLAG = 8'h10;
    localparam logic [7:0] OCW3_MASK = 8'h98;
    localparam logic [7:0] OCW3_CODE = 8'h08;
    localparam logic [7:0] EOI_FLAG  = 8'h20;

    localparam int SNGL_BIT = 1;  // ICW1 single mode
    localparam int AEOI_BIT = 1;  // ICW4 auto end of interrupt
    localparam int RR_BIT   = 1;  // OCW3 read register enable
    localparam int RIS_BIT  = 0;  // OCW3 read in-service select

    typedef struct packed {
        action_t    action;
        logic       port_select;
        logic [7:0] write_data;
        logic [2:0] irq_line;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       vector_valid;
        logic [7:0] vector;
    } result_t;

    typedef struct packed {
        logic       found;
        logic [2:0] idx;
    } prio_t;

    // Lowest set bit wins
    function automatic prio_t lowest_set(input logic [7:0] bits);
        prio_t p;
        p.found = 1'b0;
        p.idx   = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (bits[i]) begin
                p.found = 1'b1;
                p.idx   = 3'(i);
            end
        end
        return p;
    endfunction

endpackage

// ----- src/pic_core.sv -----
// ----------------------------------------------------------------------------
// pic_core: controller state and single-pass beat decode
// Computes the result for the held beat and updates state when it retires.
// ----------------------------------------------------------------------------
module pic_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  pic_pkg::item_t    item,
    output pic_pkg::result_t  result
);
    import pic_pkg::*;

    logic [7:0] mask_bits_reg,       mask_bits_next;
    logic [7:0] request_bits_reg,    request_bits_next;
    logic [7:0] in_service_bits_reg, in_service_bits_next;
    logic [2:0] init_word_step_reg,  init_word_step_next;
    logic       read_service_reg,    read_service_next;
    logic [7:0] icw1_reg,            icw1_next;
    logic [7:0] icw2_reg,            icw2_next;
    logic [7:0] icw4_reg,            icw4_next;

    always_comb begin
        prio_t      eoi_pick;
        prio_t      ack_pick;
        logic [2:0] step_eff;

        mask_bits_next       = mask_bits_reg;
        request_bits_next    = request_bits_reg;
        in_service_bits_next = in_service_bits_reg;
        init_word_step_next  = init_word_step_reg;
        read_service_next    = read_service_reg;
        icw1_next            = icw1_reg;
        icw2_next            = icw2_reg;
        icw4_next            = icw4_reg;
        result               = '0;

        eoi_pick = lowest_set(in_service_bits_reg);
        ack_pick = lowest_set(request_bits_reg & ~mask_bits_reg & ~in_service_bits_reg);
        step_eff = (init_word_step_reg == STEP_ICW3 && icw1_reg[SNGL_BIT])
                 ? STEP_ICW4 : init_word_step_reg;

        unique case (item.action)
            ACT_READ: begin
                if (!item.port_select)
                    result.read_data = read_service_reg ? in_service_bits_reg
                                                        : request_bits_reg;
                else
                    result.read_data = mask_bits_reg;
            end
            ACT_WRITE: begin
                if (!item.port_select) begin
                    if ((item.write_data & ICW1_FLAG) != 8'd0) begin
                        // restart initialization
                        mask_bits_next      = 8'd0;
                        icw1_next           = item.write_data;
                        init_word_step_next = STEP_ICW2;
                    end else begin
                        if ((item.write_data & OCW3_MASK) == OCW3_CODE
                            && item.write_data[RR_BIT])
                            read_service_next = item.write_data[RIS_BIT];
                        if ((item.write_data & EOI_FLAG) != 8'd0 && eoi_pick.found)
                            in_service_bits_next = in_service_bits_reg
                                                 & ~(8'd1 << eoi_pick.idx);
                    end
                end else if (step_eff < STEP_DONE) begin
                    unique case (step_eff)
                        STEP_ICW1: icw1_next = item.write_data;
                        STEP_ICW2: icw2_next = item.write_data;
                        STEP_ICW4: icw4_next = item.write_data;
                        default:   ;  // ICW0 and ICW3 carry no behavior here
                    endcase
                    init_word_step_next = step_eff + 3'd1;
                end else begin
                    mask_bits_next = item.write_data;
                end
            end
            ACT_RAISE: begin
                request_bits_next = request_bits_reg | (8'd1 << item.irq_line);
            end
            ACT_ACK: begin
                if (ack_pick.found) begin
                    request_bits_next = request_bits_reg & ~(8'd1 << ack_pick.idx);
                    if (!icw4_reg[AEOI_BIT])
                        in_service_bits_next = in_service_bits_reg
                                             | (8'd1 << ack_pick.idx);
                    result.vector_valid = 1'b1;
                    result.vector       = icw2_reg + {5'd0, ack_pick.idx};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mask_bits_reg       <= '0;
            request_bits_reg    <= '0;
            in_service_bits_reg <= '0;
            init_word_step_reg  <= '0;
            read_service_reg    <= 1'b0;
            icw1_reg            <= '0;
            icw2_reg            <= '0;
            icw4_reg            <= '0;
        end else if (fire) begin
            mask_bits_reg       <= mask_bits_next;
            request_bits_reg    <= request_bits_next;
            in_service_bits_reg <= in_service_bits_next;
            init_word_step_reg  <= init_word_step_next;
            read_service_reg    <= read_service_next;
            icw1_reg            <= icw1_next;
            icw2_reg            <= icw2_next;
            icw4_reg            <= icw4_next;
        end
    end

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        init_word_step_reg <= STEP_DONE)
        else $error("init word step out of range");

    a_vector_only_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
        result.vector_valid |-> item.action == ACT_ACK)
        else $error("vector reported outside acknowledge");

    a_raise_sets_request: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.action == ACT_RAISE |=> request_bits_reg[$past(item.irq_line)])
        else $error("raised line not latched");

    a_ack_enters_service: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.vector_valid && !icw4_reg[AEOI_BIT]
        |=> in_service_bits_reg != 8'd0)
        else $error("acknowledged line not in service");

endmodule

// ----- src/pic_interrupt_controller_top.sv -----
// ----------------------------------------------------------------------------
// pic_interrupt_controller_top: 8259-style interrupt controller
// Path: input stage register, one decode pass, then result stage register.
// Throughput: 1 beat per cycle while out_ready keeps the result stage draining.
// Reset: asynchronous active low; clears mask, request, in-service, ICW step,
// read select and the stored init words; both stages come up empty.
// ----------------------------------------------------------------------------
module pic_interrupt_controller_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic       port_select,
    input  logic [7:0] write_data,
    input  logic [2:0] irq_line,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       vector_valid,
    output logic [7:0] vector
);
    import pic_pkg::*;

    // Input stage: holds one beat waiting for the decode pass
    logic    in_full_reg;
    item_t   item_reg;

    // Result stage: holds one finished beat for the consumer
    logic    out_full_reg;
    result_t result_reg;

    result_t result_comb;
    logic    advance;

    // Advance the held beat into the result register whenever that register
    // is empty or being drained this cycle.
    assign advance  = in_full_reg && (!out_full_reg || out_ready);
    // Take a new beat whenever the input stage empties this cycle.
    assign in_ready = !in_full_reg || advance;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end else begin
            if (in_ready)
                in_full_reg <= in_valid;
            if (advance)
                out_full_reg <= 1'b1;
            else if (out_ready)
                out_full_reg <= 1'b0;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            item_reg.action      <= action_t'(action);
            item_reg.port_select <= port_select;
            item_reg.write_data  <= write_data;
            item_reg.irq_line    <= irq_line;
        end
        if (advance)
            result_reg <= result_comb;
    end

    // State and decode; state commits when the beat advances
    pic_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .result (result_comb)
    );

    assign out_valid    = out_full_reg;
    assign read_data    = result_reg.read_data;
    assign vector_valid = result_reg.vector_valid;
    assign vector       = result_reg.vector;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for pic_interrupt_controller_top
// A short table of directed beats walks reset values, the init word sequence
// (single and cascade), masking, EOI, the in-service read select, auto-EOI
// and vector wrap. A long random stream of raises, acks, reads and command
// and data writes follows. Every response beat is compared against a
// behavioral copy of the controller held in this bench, or against a
// hand-derived response for checked table rows. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    import pic_pkg::*;

    localparam int RANDOM_BEATS = 1350;
    localparam int DRAIN_CYCLES = 12;
    localparam int ICW1_SLOT    = 1;        // where ICW1 lands in the init words
    localparam int TIMEOUT      = 20_000_000;

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic       clk;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [1:0] action      = ACT_READ;
    logic       port_select = 1'b0;
    logic [7:0] write_data  = 8'h00;
    logic [2:0] irq_line    = 3'd0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] read_data;
    logic       vector_valid;
    logic [7:0] vector;

    pic_interrupt_controller_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .port_select  (port_select),
        .write_data   (write_data),
        .irq_line     (irq_line),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .vector_valid (vector_valid),
        .vector       (vector)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the controller state
    // ------------------------------------------------------------------------
    logic [7:0] pic_mask;
    logic [7:0] pic_irr;
    logic [7:0] pic_isr;
    logic [2:0] init_step;
    logic       read_isr_sel;
    logic [7:0] icw_words [5];

    result_t    expected_responses [$];
    result_t    want;

    int         n_errors    = 0;
    int         n_results   = 0;
    int         n_granted   = 0;
    int         n_empty_ack = 0;
    int         n_reads     = 0;
    int         n_restarts  = 0;
    int         n_eoi       = 0;
    int         stall_left  = 0;
    bit         quiet       = 1'b0;   // when set, neither side idles

    // Hard stop in case the pipeline hangs
    initial
    begin
        #(TIMEOUT);
        $display("Timeout: %0d responses still outstanding", expected_responses.size());
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        n_errors++;
    endtask

    // Advance the shadow state by one accepted beat and form its response
    task automatic apply_beat(input item_t b, output result_t r);
        logic [7:0] serviceable;
        bit         hit;
        r   = '0;
        hit = 1'b0;
        case (b.action)
            ACT_READ:
            begin
                n_reads++;
                if (b.port_select == 1'b0)
                    r.read_data = read_isr_sel ? pic_isr : pic_irr;
                else
                    r.read_data = pic_mask;
            end
            ACT_WRITE:
            begin
                if (b.port_select == 1'b0)
                begin
                    if ((b.write_data & ICW1_FLAG) != 8'h00)
                    begin
                        // ICW1 clears the mask and restarts the init sequence, nothing else
                        pic_mask              = 8'h00;
                        icw_words[ICW1_SLOT]  = b.write_data;
                        init_step             = STEP_ICW2;
                        n_restarts++;
                    end
                    else
                    begin
                        if ((b.write_data & OCW3_MASK) == OCW3_CODE && b.write_data[RR_BIT])
                            read_isr_sel = b.write_data[RIS_BIT];
                        // non-specific EOI drops the lowest in-service bit
                        if ((b.write_data & EOI_FLAG) != 8'h00)
                            for (int i = 0; i < 8; i++)
                                if (!hit && pic_isr[i])
                                begin
                                    pic_isr[i] = 1'b0;
                                    hit        = 1'b1;
                                    n_eoi++;
                                end
                    end
                end
                else
                begin
                    // single mode skips ICW3
                    if (init_step == STEP_ICW3 && icw_words[ICW1_SLOT][SNGL_BIT])
                        init_step = STEP_ICW4;
                    if (init_step < STEP_DONE)
                    begin
                        icw_words[init_step] = b.write_data;
                        init_step            = init_step + 3'd1;
                    end
                    else
                        pic_mask = b.write_data;
                end
            end
            ACT_RAISE:
                pic_irr[b.irq_line] = 1'b1;
            default:
            begin
                serviceable = pic_irr & ~pic_mask & ~pic_isr;
                for (int i = 0; i < 8; i++)
                    if (!hit && serviceable[i])
                    begin
                        hit        = 1'b1;
                        pic_irr[i] = 1'b0;
                        if (!icw_words[STEP_ICW4][AEOI_BIT])
                            pic_isr[i] = 1'b1;
                        r.vector_valid = 1'b1;
                        r.vector       = icw_words[STEP_ICW2] + 8'(i);
                    end
                if (hit)
                    n_granted++;
                else
                    n_empty_ack++;
            end
        endcase
    endtask

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Random beat: the interrupt flow (raise, ack, EOI) dominates, with
    // mask writes, status reads and occasional re-initialization mixed in.
    // Fields the action ignores still carry random values.
    // ------------------------------------------------------------------------
    function automatic item_t random_beat();
        item_t       b;
        int unsigned pick;
        b.action      = ACT_READ;
        b.port_select = 1'($urandom_range(0, 1));
        b.write_data  = 8'($urandom);
        b.irq_line    = 3'($urandom_range(0, 7));
        pick          = $urandom_range(0, 99);
        if (pick < 18)
            b.action = ACT_READ;
        else if (pick < 42)
            b.action = ACT_RAISE;
        else if (pick < 66)
            b.action = ACT_ACK;
        else
        begin
            b.action = ACT_WRITE;
            if (pick < 84)
            begin
                b.port_select = 1'b0;
                case ($urandom_range(0, 7))
                    0:       b.write_data = b.write_data | ICW1_FLAG;
                    1, 2, 3: b.write_data = (b.write_data & ~ICW1_FLAG) | EOI_FLAG;
                    4, 5:    b.write_data = (b.write_data & ~OCW3_MASK) | OCW3_CODE;
                    default: b.write_data = b.write_data & ~ICW1_FLAG;
                endcase
            end
            else
            begin
                // keep most masks sparse so acks still find work
                b.port_select = 1'b1;
                if ($urandom_range(0, 3) != 0)
                    b.write_data = b.write_data & 8'($urandom) & 8'($urandom);
            end
        end
        return b;
    endfunction

    // Drive one beat, hold it until accepted, then log what it must return
    task automatic send_beat(input item_t b, input bit use_typed, input result_t typed);
        int      gap;
        result_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action      <= b.action;
        port_select <= b.port_select;
        write_data  <= b.write_data;
        irq_line    <= b.irq_line;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        apply_beat(b, r);
        expected_responses.push_back(use_typed ? typed : r);
    endtask

    // ------------------------------------------------------------------------
    // Directed table. Rows with checked set carry a hand-derived response;
    // the rest take theirs from the shadow model.
    // ------------------------------------------------------------------------
    typedef struct {
        action_t    act;
        logic       port;
        logic [7:0] data;
        logic [2:0] line;
        bit         checked;
        result_t    resp;
    } dir_row_t;

    dir_row_t dir_table [27] = '{
        // reset values, nothing to serve
        '{ACT_READ,  1'b0, 8'h00, 3'd0, 1'b1, '{8'h00, 1'b0, 8'h00}},
        // a data-port write right after reset advances the init word step, not the mask
        '{ACT_WRITE, 1'b1, 8'hFF, 3'd7, 1'b0, '0},
        '{ACT_READ,  1'b1, 8'h00, 3'd0, 1'b1, '{8'h00, 1'b0, 8'h00}},
        '{ACT_ACK,   1'b0, 8'h00, 3'd0, 1'b1, '{8'h00, 1'b0, 8'h00}},
        // single mode: ICW1, ICW2 = 0xFE, ICW3 skipped, ICW4, then mask line 7
        '{ACT_WRITE, 1'b0, 8'h12, 3'd0, 1'b0, '0},
        '{ACT_WRITE, 1'b1, 8'hFE, 3'd0, 1'b0, '0},
        '{ACT_WRITE, 1'b1, 8'h00, 3'd0, 1'b0, '0},
        '{ACT_WRITE, 1'b1, 8'h80, 3'd0, 1'b0, '0},
        '{ACT_RAISE, 1'b0, 8'h00, 3'd7, 1'b0, '0},
        '{ACT_RAISE, 1'b0, 8'h00, 3'd0, 1'b0, '0},
        '{ACT_RAISE, 1'b0, 8'h00, 3'd5, 1'b0, '0},
        // line 0 first; line 0 in service does not block line 5; vector wraps
        '{ACT_ACK,   1'b0, 8'h00, 3'd0, 1'b1, '{8'h00, 1'b1, 8'hFE}},
        '{ACT_ACK,   1'b0, 8'h00, 3'd0, 1'b1, '{8'h00, 1'b1, 8'h03}},
        // only masked line 7 left
        '{ACT_ACK,   1'b0, 8'h00, 3'd0, 1'b1, '{8'h00, 1'b0, 8'h00}},
        // OCW3 selects the in-service register for status reads
        '{ACT_WRITE, 1'b0, 8'h0B, 3'd0, 1'b0, '0},
        '{ACT_READ,  1'b0, 8'h00, 3'd0, 1'b1, '{8'h21, 1'b0, 8'h00}},
        // non-specific EOI drops line 0
        '{ACT_WRITE, 1'b0, 8'h20, 3'd0, 1'b0, '0},
        '{ACT_READ,  1'b0, 8'h00, 3'd0, 1'b1, '{8'h20, 1'b0, 8'h00}},
        // unmask, line 7 now served
        '{ACT_WRITE, 1'b1, 8'h00, 3'd0, 1'b0, '0},
        '{ACT_ACK,   1'b0, 8'h00, 3'd0, 1'b1, '{8'h00, 1'b1, 8'h05}},
        // cascade mode with ICW3 and auto-EOI
        '{ACT_WRITE, 1'b0, 8'h11, 3'd0, 1'b0, '0},
        '{ACT_WRITE, 1'b1, 8'h40, 3'd0, 1'b0, '0},
        '{ACT_WRITE, 1'b1, 8'h04, 3'd0, 1'b0, '0},
        '{ACT_WRITE, 1'b1, 8'h02, 3'd0, 1'b0, '0},
        '{ACT_RAISE, 1'b0, 8'h00, 3'd3, 1'b0, '0},
        '{ACT_ACK,   1'b0, 8'h00, 3'd0, 1'b1, '{8'h00, 1'b1, 8'h43}},
        // auto-EOI leaves line 3 out of service
        '{ACT_READ,  1'b0, 8'h00, 3'd0, 1'b1, '{8'hA0, 1'b0, 8'h00}}
    };

    // ------------------------------------------------------------------------
    // Response side: check each beat, then pick the next ready level
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (expected_responses.size() == 0)
                report_mismatch($sformatf("response beat %0d with nothing pending", n_results));
            else
            begin
                want = expected_responses.pop_front();
                if (read_data !== want.read_data)
                    report_mismatch($sformatf("beat %0d read_data %0h, want %0h",
                                              n_results, read_data, want.read_data));
                if (vector_valid !== want.vector_valid)
                    report_mismatch($sformatf("beat %0d vector_valid %0b, want %0b",
                                              n_results, vector_valid, want.vector_valid));
                if (vector !== want.vector)
                    report_mismatch($sformatf("beat %0d vector %0h, want %0h",
                                              n_results, vector, want.vector));
            end
        end
        // hold off the response channel now and then
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
                stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        item_t b;
        pic_mask     = 8'h00;
        pic_irr      = 8'h00;
        pic_isr      = 8'h00;
        init_step    = 3'd0;
        read_isr_sel = 1'b0;
        foreach (icw_words[i])
            icw_words[i] = 8'h00;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
        begin
            b.action      = dir_table[i].act;
            b.port_select = dir_table[i].port;
            b.write_data  = dir_table[i].data;
            b.irq_line    = dir_table[i].line;
            send_beat(b, dir_table[i].checked, dir_table[i].resp);
        end

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            // switch idling off for whole stretches now and then
            if (n % 64 == 0)
                quiet = ($urandom_range(0, 4) == 0);
            send_beat(random_beat(), 1'b0, '0);
        end
        in_valid <= 1'b0;
        quiet     = 1'b0;

        // drain, then let the pipeline settle to catch stray beats
        wait (expected_responses.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d beats: %0d vectors granted, %0d acks with nothing to serve, %0d reads",
                 n_results, n_granted, n_empty_ack, n_reads);
        $display("Init restarts %0d, EOI clears %0d, mismatches %0d",
                 n_restarts, n_eoi, n_errors);
        if (n_errors == 0 && expected_responses.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/pic_pkg.sv
src/pic_core.sv
src/pic_interrupt_controller_top.sv
dv/tb_top.sv
